// ===== rtl/alm_pkg.sv =====
// Shared types and constants for the audio level meter ballistics block.
// No dependencies; imported by the channel interfaces and the top level.
package alm_pkg;

   // Channel count and index widths
   localparam int CHANNELS  = 8;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_W      = 3;

   // Field widths
   localparam int DB_W      = 16;
   localparam int LVL_W     = 24;
   localparam int TIME_W    = 32;
   localparam int RATE_W    = 16;
   localparam int ELAPSED_W = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_DB         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_RATE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_FALL_RATE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME_MS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_LEVEL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_THRESHOLD = 3'd5;

   // Register reset values
   localparam logic signed [DB_W-1:0] FLOOR_RESET          = -16'sd15360;
   localparam logic [RATE_W-1:0]      RELEASE_RATE_RESET   = 16'd6656;
   localparam logic [RATE_W-1:0]      HOLD_FALL_RATE_RESET = 16'd6144;
   localparam logic [RATE_W-1:0]      HOLD_TIME_RESET      = 16'd1400;
   localparam logic [LVL_W-1:0]       SILENCE_RESET        = 24'd1;
   localparam logic [RATE_W-1:0]      CHANGE_THR_RESET     = 16'd26;

   // Shared multiplier operand width and product width
   localparam int MUL_W  = 25;
   localparam int PROD_W = 2 * MUL_W;

   // 20*log10(2) in Q16
   localparam logic [MUL_W-1:0] LOG_K = 25'd394566;

   // floor(x/1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^24
   localparam logic [MUL_W-1:0] RECIP_1000  = 25'd17179870;
   localparam int               RECIP_SHIFT = 34;
   localparam logic [LVL_W-1:0] HALF_MS_RND = 24'd500;

   localparam logic [ELAPSED_W-1:0] MAX_ELAPSED = 8'd250;

   // Sequencer step counts
   localparam int NORM_STEPS  = 5;
   localparam int SQR_ROUNDS  = 16;
   localparam int DECAY_STEPS = 4;
   localparam int STEP_W      = 4;

   // Decay amount width: at most 65535*250/1000 rounded
   localparam int DEC_W = 15;

   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic              frame_start;
      logic [TIME_W-1:0] now_ms;
      logic [LVL_W-1:0]  level_linear;
   } req_payload_type;

   typedef struct packed {
      logic [CH_W-1:0]        out_channel;
      logic signed [DB_W-1:0] fast_db;
      logic signed [DB_W-1:0] slow_db;
      logic signed [DB_W-1:0] hold_db;
      logic                   changed;
   } rsp_payload_type;

endpackage

// ===== rtl/alm_channels_if.sv =====
// Valid/ready channel interfaces for level beats in and meter beats out.
// Depends on alm_pkg for the payload types.
interface alm_req_if;
   import alm_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface alm_rsp_if;
   import alm_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/audio_level_meter_ballistics.sv =====
// Peak meter ballistics: dB conversion, slow bar release and peak hold per channel.
// Depends on alm_pkg and the channel interfaces in alm_channels_if.sv.
// An accepted beat runs the normalise, squaring loop, magnitude, scale, round, decay and
//   update steps; a silent level goes straight to decay and update. One beat is in work
//   at a time, as the steps share the 25x25 multiplier: 16 squaring rounds of the log2
//   loop, one scale, four decay. The update step waits until the result register is free.
// Reset (synchronous, active high) restores register defaults, sets all channel
//   levels to the default floor and clears timestamps; the block is ready at once.
module audio_level_meter_ballistics (
   input  logic                             clock,
   input  logic                             reset,
   alm_req_if.sink                          req_bus,
   alm_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [alm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [alm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import alm_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_NORM  = 3'd1;
   localparam logic [2:0] S_SQR   = 3'd2;
   localparam logic [2:0] S_MAG   = 3'd3;
   localparam logic [2:0] S_LOGK  = 3'd4;
   localparam logic [2:0] S_LOGR  = 3'd5;
   localparam logic [2:0] S_DECAY = 3'd6;
   localparam logic [2:0] S_UPD   = 3'd7;

   // Configuration registers
   logic signed [DB_W-1:0] floor_db_ff;
   logic [RATE_W-1:0]      release_rate_ff;
   logic [RATE_W-1:0]      hold_fall_rate_ff;
   logic [RATE_W-1:0]      hold_time_ff;
   logic [LVL_W-1:0]       silence_ff;
   logic [RATE_W-1:0]      change_thr_ff;

   // Per-channel state
   logic signed [DB_W-1:0] fast_ff  [CHANNELS];
   logic signed [DB_W-1:0] slow_ff  [CHANNELS];
   logic signed [DB_W-1:0] hold_ff  [CHANNELS];
   logic [TIME_W-1:0]      stamp_ff [CHANNELS];
   logic [TIME_W-1:0]      last_time_ff;
   logic [ELAPSED_W-1:0]   elapsed_ff;

   // Sequencer
   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Working registers for the beat in flight
   logic [CH_W-1:0]        ch_ff;
   logic [TIME_W-1:0]      now_ff;
   logic [LVL_W-1:0]       m_ff;
   logic [4:0]             p_ff;
   logic [15:0]            frac_ff;
   logic                   neg_ff;
   logic [20:0]            mag_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic signed [DB_W-1:0] db_ff;
   logic [LVL_W-1:0]       x_ff;
   logic [DEC_W-1:0]       dec_rel_ff;
   logic [DEC_W-1:0]       dec_hold_ff;

   // Output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic accept, in_range, silent, out_free;
   logic [TIME_W-1:0]    time_diff;
   logic [ELAPSED_W-1:0] elapsed_new;

   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [25:0]       sq;

   logic signed [5:0]  exp_s;
   logic signed [21:0] v_s;
   logic [17:0]        round_sum;

   logic [CH_IDX_W-1:0]    idx;
   logic signed [DB_W-1:0] fast_old, slow_old, hold_old;
   logic signed [DB_W:0]   fdiff, slow_fell, hold_fell;
   logic [DB_W:0]          fdiff_abs;
   logic signed [DB_W-1:0] slow_lo, slow_new, hold_new;
   logic                   slow_attack, hold_set, hold_expired;
   logic [TIME_W-1:0]      hold_age;
   logic                   changed;

   assign accept   = req_bus.valid && req_bus.ready;
   assign in_range = 32'(req_bus.data.channel) < 32'(CHANNELS);
   assign silent   = req_bus.data.level_linear <= silence_ff;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // Elapsed time since the last frame start, clamped to MAX_ELAPSED; backwards time gives zero
   always_comb begin
      time_diff = req_bus.data.now_ms - last_time_ff;
      if (time_diff[TIME_W-1]) begin
         elapsed_new = '0;
      end else if (time_diff > 32'(MAX_ELAPSED)) begin
         elapsed_new = MAX_ELAPSED;
      end else begin
         elapsed_new = time_diff[ELAPSED_W-1:0];
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQR: begin
            mul_a = MUL_W'(m_ff);
            mul_b = MUL_W'(m_ff);
         end
         S_LOGK: begin
            mul_a = MUL_W'(mag_ff);
            mul_b = LOG_K;
         end
         S_DECAY: begin
            case (step_ff[1:0])
               2'd0: begin
                  mul_a = MUL_W'(release_rate_ff);
                  mul_b = MUL_W'(elapsed_ff);
               end
               2'd2: begin
                  mul_a = MUL_W'(hold_fall_rate_ff);
                  mul_b = MUL_W'(elapsed_ff);
               end
               default: begin
                  mul_a = MUL_W'(x_ff);
                  mul_b = RECIP_1000;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;
   assign sq   = prod[48:23];

   // Signed log2 in Q16 and rounding of the scaled product
   assign exp_s     = $signed({1'b0, p_ff}) - 6'sd23;
   assign v_s       = $signed({exp_s, frac_ff});
   assign round_sum = prod_ff[41:24] + 18'(prod_ff[23]);

   // Meter update for the channel in flight
   always_comb begin
      idx      = CH_IDX_W'(ch_ff);
      fast_old = fast_ff[idx];
      slow_old = slow_ff[idx];
      hold_old = hold_ff[idx];

      fdiff     = $signed({db_ff[DB_W-1], db_ff}) - $signed({fast_old[DB_W-1], fast_old});
      fdiff_abs = fdiff[DB_W] ? 17'(-fdiff) : 17'(fdiff);

      slow_attack = db_ff >= slow_old;
      slow_fell   = $signed({slow_old[DB_W-1], slow_old}) - $signed({2'b00, dec_rel_ff});
      slow_lo     = (db_ff > floor_db_ff) ? db_ff : floor_db_ff;
      slow_new    = slow_attack ? db_ff
                  : (slow_fell > $signed({slow_lo[DB_W-1], slow_lo})) ? slow_fell[DB_W-1:0]
                  : slow_lo;

      hold_set     = db_ff >= hold_old;
      hold_age     = now_ff - stamp_ff[idx];
      hold_expired = hold_age > 32'(hold_time_ff);
      hold_fell    = $signed({hold_old[DB_W-1], hold_old}) - $signed({2'b00, dec_hold_ff});
      if (hold_set) begin
         hold_new = db_ff;
      end else if (!hold_expired) begin
         hold_new = hold_old;
      end else if (hold_fell > $signed({floor_db_ff[DB_W-1], floor_db_ff})) begin
         hold_new = hold_fell[DB_W-1:0];
      end else begin
         hold_new = floor_db_ff;
      end

      changed = (fdiff_abs > {1'b0, change_thr_ff}) || !slow_attack || hold_set
             || hold_expired;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (accept && in_range) begin
               state_in = silent ? S_DECAY : S_NORM;
            end
         end
         S_NORM: begin
            if (step_ff == STEP_W'(NORM_STEPS - 1)) begin
               state_in = S_SQR;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_SQR: begin
            if (step_ff == STEP_W'(SQR_ROUNDS - 1)) begin
               state_in = S_MAG;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MAG:  state_in = S_LOGK;
         S_LOGK: state_in = S_LOGR;
         S_LOGR: begin
            state_in = S_DECAY;
            step_in  = '0;
         end
         S_DECAY: begin
            if (step_ff == STEP_W'(DECAY_STEPS - 1)) begin
               state_in = S_UPD;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_UPD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         step_ff           <= '0;
         floor_db_ff       <= FLOOR_RESET;
         release_rate_ff   <= RELEASE_RATE_RESET;
         hold_fall_rate_ff <= HOLD_FALL_RATE_RESET;
         hold_time_ff      <= HOLD_TIME_RESET;
         silence_ff        <= SILENCE_RESET;
         change_thr_ff     <= CHANGE_THR_RESET;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FLOOR_DB:         floor_db_ff       <= csr_wdata[DB_W-1:0];
               CSR_RELEASE_RATE:     release_rate_ff   <= csr_wdata[RATE_W-1:0];
               CSR_HOLD_FALL_RATE:   hold_fall_rate_ff <= csr_wdata[RATE_W-1:0];
               CSR_HOLD_TIME_MS:     hold_time_ff      <= csr_wdata[RATE_W-1:0];
               CSR_SILENCE_LEVEL:    silence_ff        <= csr_wdata[LVL_W-1:0];
               CSR_CHANGE_THRESHOLD: change_thr_ff     <= csr_wdata[RATE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Frame timing: latch the timestamp and elapsed time on a frame start
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         elapsed_ff   <= '0;
      end else if (accept && req_bus.data.frame_start) begin
         last_time_ff <= req_bus.data.now_ms;
         elapsed_ff   <= elapsed_new;
      end
   end

   // Datapath for the beat in flight
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            ch_ff   <= req_bus.data.channel;
            now_ff  <= req_bus.data.now_ms;
            m_ff    <= req_bus.data.level_linear;
            p_ff    <= 5'd23;
            frac_ff <= '0;
            db_ff   <= floor_db_ff;
         end
         // Normalise by a binary search on leading zeros
         S_NORM: begin
            case (step_ff[2:0])
               3'd0: if (m_ff[23:8] == '0) begin
                  m_ff <= m_ff << 16;
                  p_ff <= p_ff - 5'd16;
               end
               3'd1: if (m_ff[23:16] == '0) begin
                  m_ff <= m_ff << 8;
                  p_ff <= p_ff - 5'd8;
               end
               3'd2: if (m_ff[23:20] == '0) begin
                  m_ff <= m_ff << 4;
                  p_ff <= p_ff - 5'd4;
               end
               3'd3: if (m_ff[23:22] == '0) begin
                  m_ff <= m_ff << 2;
                  p_ff <= p_ff - 5'd2;
               end
               default: if (!m_ff[23]) begin
                  m_ff <= m_ff << 1;
                  p_ff <= p_ff - 5'd1;
               end
            endcase
         end
         // One fraction bit per squaring round
         S_SQR: begin
            if (sq[24]) begin
               m_ff    <= sq[24:1];
               frac_ff <= {frac_ff[14:0], 1'b1};
            end else begin
               m_ff    <= sq[23:0];
               frac_ff <= {frac_ff[14:0], 1'b0};
            end
         end
         S_MAG: begin
            neg_ff <= v_s < 0;
            mag_ff <= (v_s < 0) ? 21'(-v_s) : 21'(v_s);
         end
         S_LOGK: prod_ff <= prod;
         // Round half away from zero, saturate the negative end
         S_LOGR: begin
            if (!neg_ff) begin
               db_ff <= DB_W'(round_sum);
            end else if (round_sum > 18'd32768) begin
               db_ff <= -16'sd32768;
            end else begin
               db_ff <= DB_W'(-round_sum);
            end
         end
         S_DECAY: begin
            case (step_ff[1:0])
               2'd0:    x_ff        <= prod[LVL_W-1:0] + HALF_MS_RND;
               2'd1:    dec_rel_ff  <= prod[RECIP_SHIFT +: DEC_W];
               2'd2:    x_ff        <= prod[LVL_W-1:0] + HALF_MS_RND;
               default: dec_hold_ff <= prod[RECIP_SHIFT +: DEC_W];
            endcase
         end
         default: ;
      endcase
   end

   // Channel stores: commit when the result beat is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            fast_ff[i]  <= FLOOR_RESET;
            slow_ff[i]  <= FLOOR_RESET;
            hold_ff[i]  <= FLOOR_RESET;
            stamp_ff[i] <= '0;
         end
      end else if (state_ff == S_UPD && out_free) begin
         fast_ff[idx] <= db_ff;
         slow_ff[idx] <= slow_new;
         hold_ff[idx] <= hold_new;
         if (hold_set) begin
            stamp_ff[idx] <= now_ff;
         end
      end
   end

   // Result register: load when free, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_UPD && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_UPD && out_free) begin
         rsp_data_ff.out_channel <= ch_ff;
         rsp_data_ff.fast_db     <= db_ff;
         rsp_data_ff.slow_db     <= slow_new;
         rsp_data_ff.hold_db     <= hold_new;
         rsp_data_ff.changed     <= changed;
      end
   end

`ifndef SYNTH
   // The squaring loop keeps the mantissa normalised
   a_norm_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQR || state_ff == S_MAG) |-> m_ff[LVL_W-1])
      else $error("mantissa lost normalisation in log loop");

   // The loop leaves only after its last round
   a_sqr_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQR && state_in != S_SQR) |-> step_ff == STEP_W'(SQR_ROUNDS - 1))
      else $error("log loop left early");

   // A result beat appears only from the update step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_UPD)
      else $error("result raised outside update");

   // Elapsed time stays clamped
   a_elapsed_clamp: assert property (@(posedge clock) disable iff (reset)
      elapsed_ff <= MAX_ELAPSED)
      else $error("elapsed time beyond clamp");
`endif

endmodule

// ===== bench/audio_level_meter_ballistics_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for audio_level_meter_ballistics: a directed table of level beats and
// register writes, then framed random traffic, each result checked by model or table value.
// Depends on alm_pkg, the channel interfaces in alm_channels_if.sv and the block itself.
module audio_level_meter_ballistics_test;
   import alm_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 5;
   localparam int MAX_WAIT        = 11;
   localparam int SETTLE_CYCLES   = 32;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int NUM_PHASES      = 8;
   localparam int BEATS_PER_PHASE = 150;
   localparam int PRESSURE_PHASE  = 3;
   localparam int MAX_REPORTS     = 50;
   localparam int RUN_LIMIT_NS    = 5_000_000;
   localparam int MAX_GAP_MS      = 250;

   // 20*log10(2) in Q16
   localparam longint unsigned DB_PER_OCTAVE_Q16 = 64'd394566;

   // Indexes past the register list; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   localparam logic [DB_W-1:0] FLOOR_MID = 16'hD800;   // -40 dB

   typedef struct {
      logic signed [DB_W-1:0] floor_db;
      logic [RATE_W-1:0]      release_rate;
      logic [RATE_W-1:0]      hold_fall_rate;
      logic [RATE_W-1:0]      hold_time_ms;
      logic [LVL_W-1:0]       silence_level;
      logic [RATE_W-1:0]      change_threshold;
   } meter_settings_type;

   typedef struct {
      bit                      is_csr;
      logic [CSR_IDX_W-1:0]    reg_idx;
      logic [CSR_DATA_W-1:0]   reg_val;
      req_payload_type         beat;
      bit                      typed;
      rsp_payload_type         want;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   alm_req_if req_ch ();
   alm_rsp_if rsp_ch ();

   audio_level_meter_ballistics dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // Model state: per-channel meter levels, peak timestamps and frame timing
   meter_settings_type     cfg;
   logic signed [DB_W-1:0] inst_db [CHANNELS];
   logic signed [DB_W-1:0] bar_db [CHANNELS];
   logic signed [DB_W-1:0] peak_db [CHANNELS];
   logic [TIME_W-1:0]      peak_since_ms [CHANNELS];
   logic [TIME_W-1:0]      frame_mark_ms;
   logic [ELAPSED_W-1:0]   frame_gap_ms;
   logic [LVL_W-1:0]       chan_level [CHANNELS];

   rsp_payload_type pending_readings [$];
   script_row_type  script_q [$];

   int  mismatch_count = 0;
   int  beats_sent     = 0;
   int  directed_beats = 0;
   int  results_seen   = 0;
   int  writes_done    = 0;
   int  input_stalls   = 0;
   int  hold_offs_done = 0;
   bit  send_calm      = 1'b0;
   bit  rsp_calm       = 1'b0;
   bit  hold_off_req   = 1'b0;

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Linear Q1.23 to Q8.8 dB: log2 by repeated squaring, then scale by 20*log10(2)
   function automatic int lin_to_decibel(input logic [LVL_W-1:0] lvl);
      int top, frac, v, db;
      longint unsigned m, mag, r;
      top = 23;
      while (top > 0 && lvl[top] == 1'b0) top--;
      m = 64'(lvl) << (23 - top);
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 23;
         frac = frac << 1;
         if (m >= (64'd1 << 24)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      v = (top - 23) * 65536 + frac;
      mag = 64'((v < 0) ? -v : v);
      r = (mag * DB_PER_OCTAVE_Q16 + (64'd1 << 23)) >> 24;
      db = (v < 0) ? -int'(r) : int'(r);
      if (db < -32768) db = -32768;
      return db;
   endfunction

   // dB fallen over the current frame gap, rounded to the nearest Q8.8 step
   function automatic int fall_step(input logic [RATE_W-1:0] rate);
      return (int'(rate) * int'(frame_gap_ms) + 500) / 1000;
   endfunction

   // Advance the model by one level beat and return the reading it should produce
   function automatic rsp_payload_type advance_meter(input req_payload_type b);
      logic [TIME_W-1:0] span, since;
      int ch, db, diff, fell, lo, bar, peak, flo;
      bit changed;
      rsp_payload_type r;
      if (b.frame_start) begin
         span = b.now_ms - frame_mark_ms;
         if (span[31]) span = '0;
         if (span > 32'(MAX_GAP_MS)) span = 32'(MAX_GAP_MS);
         frame_gap_ms = span[ELAPSED_W-1:0];
         frame_mark_ms = b.now_ms;
      end
      ch = int'(b.channel);
      flo = int'(cfg.floor_db);
      db = (b.level_linear <= cfg.silence_level) ? flo : lin_to_decibel(b.level_linear);
      changed = 1'b0;
      diff = db - int'(inst_db[ch]);
      if (diff < 0) diff = -diff;
      if (diff > int'(cfg.change_threshold)) changed = 1'b1;
      inst_db[ch] = 16'(db);

      // Bar: instant attack, linear release clamped to the floor or the new level
      bar = int'(bar_db[ch]);
      if (db >= bar) begin
         bar = db;
      end else begin
         fell = bar - fall_step(cfg.release_rate);
         lo = (db > flo) ? db : flo;
         bar = (fell > lo) ? fell : lo;
         changed = 1'b1;
      end
      bar_db[ch] = 16'(bar);

      // Peak: restart the hold on a new peak, fall once the hold time has run out
      peak = int'(peak_db[ch]);
      since = b.now_ms - peak_since_ms[ch];
      if (db >= peak) begin
         peak = db;
         peak_since_ms[ch] = b.now_ms;
         changed = 1'b1;
      end else if (since > 32'(cfg.hold_time_ms)) begin
         fell = peak - fall_step(cfg.hold_fall_rate);
         peak = (fell > flo) ? fell : flo;
         changed = 1'b1;
      end
      peak_db[ch] = 16'(peak);

      r.out_channel = b.channel;
      r.fast_db = inst_db[ch];
      r.slow_db = bar_db[ch];
      r.hold_db = peak_db[ch];
      r.changed = changed;
      return r;
   endfunction

   // Random level for a channel: silence edges, extremes, log-spread and gentle falls
   function automatic logic [LVL_W-1:0] pick_level(input int c);
      logic [LVL_W-1:0] lvl, raw;
      case ($urandom_range(0, 9)) inside
         0: lvl = '0;
         1: lvl = cfg.silence_level;
         2: lvl = (cfg.silence_level == 24'hFFFFFF) ? cfg.silence_level
                                                     : cfg.silence_level + 24'd1;
         3: lvl = 24'($urandom_range(1, 255));
         4: lvl = 24'($urandom());
         5: lvl = 24'hFFFFFF;
         6, 7: begin
            raw = 24'($urandom());
            lvl = raw >> $urandom_range(0, 23);
         end
         default: lvl = chan_level[c] - (chan_level[c] >> $urandom_range(1, 6));
      endcase
      chan_level[c] = lvl;
      return lvl;
   endfunction

   function automatic script_row_type level_row(input int ch, input bit fs,
                                                input logic [TIME_W-1:0] now,
                                                input logic [LVL_W-1:0] lvl);
      script_row_type row;
      row.is_csr = 1'b0;
      row.reg_idx = '0;
      row.reg_val = '0;
      row.beat.channel = 3'(ch);
      row.beat.frame_start = fs;
      row.beat.now_ms = now;
      row.beat.level_linear = lvl;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic script_row_type known_row(input int ch, input bit fs,
                                                input logic [TIME_W-1:0] now,
                                                input logic [LVL_W-1:0] lvl,
                                                input rsp_payload_type want);
      script_row_type row;
      row = level_row(ch, fs, now, lvl);
      row.typed = 1'b1;
      row.want = want;
      return row;
   endfunction

   function automatic script_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] value);
      script_row_type row;
      row = level_row(0, 1'b0, '0, '0);
      row.is_csr = 1'b1;
      row.reg_idx = idx;
      row.reg_val = value;
      return row;
   endfunction

   // Offer one beat, hold it until taken, then log its expected reading
   task automatic send_beat(input req_payload_type b, input bit typed,
                            input rsp_payload_type want);
      int gap;
      rsp_payload_type predicted;
      gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= b;
      @(posedge clock);
      while (!req_ch.ready) begin
         input_stalls++;
         @(posedge clock);
      end
      predicted = advance_meter(b);
      pending_readings.push_back(typed ? want : predicted);
      beats_sent++;
   endtask

   // Drop valid and wait until every reading is back and the block has settled
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FLOOR_DB:         cfg.floor_db = value[DB_W-1:0];
         CSR_RELEASE_RATE:     cfg.release_rate = value[RATE_W-1:0];
         CSR_HOLD_FALL_RATE:   cfg.hold_fall_rate = value[RATE_W-1:0];
         CSR_HOLD_TIME_MS:     cfg.hold_time_ms = value[RATE_W-1:0];
         CSR_SILENCE_LEVEL:    cfg.silence_level = value[LVL_W-1:0];
         CSR_CHANGE_THRESHOLD: cfg.change_threshold = value[RATE_W-1:0];
         default: ;
      endcase
      writes_done++;
      @(posedge clock);
   endtask

   // Result side: random stalls, one long hold-off on request, check every beat
   initial begin : meter_receiver
      int stall;
      rsp_payload_type got, want;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge clock);
            hold_offs_done++;
         end
         stall = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got = rsp_ch.data;
         results_seen++;
         if (pending_readings.size() == 0) begin
            flag_mismatch($sformatf("reading for channel %0d with nothing expected",
                                    got.out_channel));
         end else begin
            want = pending_readings.pop_front();
            if (got.out_channel !== want.out_channel)
               flag_mismatch($sformatf("out_channel got %0d want %0d",
                                       got.out_channel, want.out_channel));
            if (got.fast_db !== want.fast_db)
               flag_mismatch($sformatf("ch %0d fast_db got %0d want %0d", want.out_channel,
                                       $signed(got.fast_db), $signed(want.fast_db)));
            if (got.slow_db !== want.slow_db)
               flag_mismatch($sformatf("ch %0d slow_db got %0d want %0d", want.out_channel,
                                       $signed(got.slow_db), $signed(want.slow_db)));
            if (got.hold_db !== want.hold_db)
               flag_mismatch($sformatf("ch %0d hold_db got %0d want %0d", want.out_channel,
                                       $signed(got.hold_db), $signed(want.hold_db)));
            if (got.changed !== want.changed)
               flag_mismatch($sformatf("ch %0d changed got %0b want %0b", want.out_channel,
                                       got.changed, want.changed));
         end
      end
   end

   initial begin : level_stimulus
      meter_settings_type next_cfg;
      req_payload_type b;
      logic [TIME_W-1:0] now_cursor;
      int phase_beats, nch, step_pick, floor_mag;

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;

      // Model starts from the reset register values and floor-level channels
      cfg.floor_db = FLOOR_RESET;
      cfg.release_rate = RELEASE_RATE_RESET;
      cfg.hold_fall_rate = HOLD_FALL_RATE_RESET;
      cfg.hold_time_ms = HOLD_TIME_RESET;
      cfg.silence_level = SILENCE_RESET;
      cfg.change_threshold = CHANGE_THR_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         inst_db[c] = FLOOR_RESET;
         bar_db[c] = FLOOR_RESET;
         peak_db[c] = FLOOR_RESET;
         peak_since_ms[c] = '0;
         chan_level[c] = '0;
      end
      frame_mark_ms = '0;
      frame_gap_ms = '0;
      now_cursor = '0;

      // Directed table: silence and full-scale extremes, frame timing corners,
      // register extremes, attack under a raised floor, ignored register indexes
      script_q.push_back(known_row(0, 1'b1, 32'd0, 24'd0,
         rsp_payload_type'{3'd0, FLOOR_RESET, FLOOR_RESET, FLOOR_RESET, 1'b1}));
      script_q.push_back(known_row(1, 1'b0, 32'd0, 24'h800000,
         rsp_payload_type'{3'd1, 16'sd0, 16'sd0, 16'sd0, 1'b1}));
      script_q.push_back(level_row(2, 1'b0, 32'd0, 24'd1));           // at silence level
      script_q.push_back(level_row(2, 1'b0, 32'd0, 24'd2));           // saturates low
      script_q.push_back(level_row(3, 1'b0, 32'd0, 24'hFFFFFF));
      script_q.push_back(level_row(7, 1'b0, 32'd0, 24'h400000));
      script_q.push_back(level_row(4, 1'b0, 32'd0, 24'h000100));
      script_q.push_back(level_row(0, 1'b1, 32'd100, 24'd0));
      script_q.push_back(level_row(1, 1'b0, 32'd100, 24'd0));         // bar release
      script_q.push_back(level_row(1, 1'b1, 32'd50, 24'd0));          // time runs backwards
      script_q.push_back(level_row(1, 1'b1, 32'd350, 24'd0));         // gap clamps
      script_q.push_back(level_row(1, 1'b1, 32'd2000, 24'd0));        // hold expires
      script_q.push_back(level_row(4, 1'b1, 32'hFFFFFF00, 24'h7FFFFF));
      script_q.push_back(level_row(4, 1'b1, 32'h00000010, 24'd0));    // timestamp wraps
      script_q.push_back(reg_row(CSR_CHANGE_THRESHOLD, 24'd0));
      script_q.push_back(level_row(3, 1'b0, 32'd16, 24'hFFFFFF));
      script_q.push_back(reg_row(CSR_RELEASE_RATE, 24'h00FFFF));
      script_q.push_back(reg_row(CSR_HOLD_FALL_RATE, 24'h00FFFF));
      script_q.push_back(reg_row(CSR_HOLD_TIME_MS, 24'd0));
      script_q.push_back(level_row(3, 1'b1, 32'd266, 24'd0));         // steepest falls
      script_q.push_back(reg_row(CSR_FLOOR_DB, 24'(FLOOR_MID)));
      script_q.push_back(level_row(5, 1'b0, 32'd266, 24'd26527));     // -50 dB, under floor
      script_q.push_back(level_row(5, 1'b0, 32'd266, 24'd0));
      script_q.push_back(reg_row(CSR_SILENCE_LEVEL, 24'hFFFFFF));
      script_q.push_back(known_row(6, 1'b0, 32'd266, 24'hFFFFFF,
         rsp_payload_type'{3'd6, -16'sd10240, -16'sd10240, -16'sd10240, 1'b1}));
      script_q.push_back(reg_row(CSR_SPARE_A, 24'hA5A5A5));
      script_q.push_back(reg_row(CSR_SPARE_B, 24'h5A5A5A));
      script_q.push_back(level_row(7, 1'b1, 32'd300, 24'h123456));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (script_q[i]) begin
         if (script_q[i].is_csr) begin
            quiesce();
            write_reg(script_q[i].reg_idx, script_q[i].reg_val);
         end else begin
            send_beat(script_q[i].beat, script_q[i].typed, script_q[i].want);
            directed_beats++;
         end
      end

      // Random phases: new settings each time, then framed traffic with some noise
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               next_cfg.floor_db = FLOOR_RESET;
               next_cfg.release_rate = RELEASE_RATE_RESET;
               next_cfg.hold_fall_rate = HOLD_FALL_RATE_RESET;
               next_cfg.hold_time_ms = HOLD_TIME_RESET;
               next_cfg.silence_level = SILENCE_RESET;
               next_cfg.change_threshold = CHANGE_THR_RESET;
            end
            1: begin
               next_cfg.floor_db = 16'sh8000;
               next_cfg.release_rate = '0;
               next_cfg.hold_fall_rate = '0;
               next_cfg.hold_time_ms = '0;
               next_cfg.silence_level = '0;
               next_cfg.change_threshold = '0;
            end
            2: begin
               next_cfg.floor_db = '0;
               next_cfg.release_rate = '1;
               next_cfg.hold_fall_rate = '1;
               next_cfg.hold_time_ms = '1;
               next_cfg.silence_level = 24'($urandom_range(0, 64));
               next_cfg.change_threshold = '1;
            end
            default: begin
               floor_mag = $urandom_range(0, 32768);
               next_cfg.floor_db = 16'(-floor_mag);
               next_cfg.release_rate = 16'($urandom());
               next_cfg.hold_fall_rate = 16'($urandom());
               next_cfg.hold_time_ms = 16'($urandom_range(0, 3000));
               next_cfg.silence_level = 24'($urandom()) >> $urandom_range(4, 23);
               next_cfg.change_threshold = 16'($urandom_range(0, 1500));
            end
         endcase
         quiesce();
         write_reg(CSR_FLOOR_DB, 24'(16'(next_cfg.floor_db)));
         write_reg(CSR_RELEASE_RATE, 24'(next_cfg.release_rate));
         write_reg(CSR_HOLD_FALL_RATE, 24'(next_cfg.hold_fall_rate));
         write_reg(CSR_HOLD_TIME_MS, 24'(next_cfg.hold_time_ms));
         write_reg(CSR_SILENCE_LEVEL, next_cfg.silence_level);
         write_reg(CSR_CHANGE_THRESHOLD, 24'(next_cfg.change_threshold));

         // Some phases run back to back on one or both sides
         send_calm = (phase == 4 || phase == 6);
         rsp_calm = (phase == 4);
         if (phase == PRESSURE_PHASE) hold_off_req = 1'b1;

         phase_beats = 0;
         while (phase_beats < BEATS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 10) begin
               b.channel = 3'($urandom_range(0, CHANNELS - 1));
               b.frame_start = 1'($urandom_range(0, 1));
               b.now_ms = 32'($urandom());
               b.level_linear = 24'($urandom());
               send_beat(b, 1'b0, '0);
               phase_beats++;
            end else begin
               // Advance frame time: mostly short steps, some long, a few backwards or random jumps
               step_pick = $urandom_range(0, 99);
               if (step_pick < 60) now_cursor += 32'($urandom_range(0, 40));
               else if (step_pick < 80) now_cursor += 32'($urandom_range(41, 400));
               else if (step_pick < 92) now_cursor += 32'($urandom_range(401, 4000));
               else if (step_pick < 97) now_cursor -= 32'($urandom_range(1, 100));
               else now_cursor = 32'($urandom());
               nch = $urandom_range(1, CHANNELS);
               for (int c = 0; c < nch; c++) begin
                  b.channel = 3'(c);
                  b.frame_start = (c == 0);
                  b.now_ms = now_cursor;
                  b.level_linear = pick_level(c);
                  send_beat(b, 1'b0, '0);
                  phase_beats++;
               end
            end
         end
      end
      send_calm = 1'b0;
      rsp_calm = 1'b0;

      quiesce();
      $display("Run covered %0d level beats (%0d directed), %0d readings checked.",
               beats_sent, directed_beats, results_seen);
      $display("Register writes %0d, receiver hold-offs %0d, input stall cycles %0d.",
               writes_done, hold_offs_done, input_stalls);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: end the run with an error once RUN_LIMIT_NS has passed
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
